// ===== rtl/core/nstc_pkg.sv =====
// Shared constants and types for the NMEA sentence type capture block.
package nstc_pkg;

  localparam int LINE_BYTES_DEF = 128;
  localparam int MAX_WORDS      = 16;

  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 24;
  localparam int WORD_W   = 64;
  localparam int WIDX_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  localparam logic [CODE_W-1:0] CODE_FIRST_RST  = 24'h474741; // "GGA"
  localparam logic [CODE_W-1:0] CODE_SECOND_RST = 24'h524D43; // "RMC"

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_SECOND = 2'd1;

  typedef enum logic [5:0] {
    PH_WAIT   = 6'b000001,
    PH_START  = 6'b000010,
    PH_HEADER = 6'b000100,
    PH_KIND0  = 6'b001000,
    PH_KIND1  = 6'b010000,
    PH_OTHER  = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } seq_t;

endpackage

// ===== rtl/core/nmea_sentence_type_capture_core.sv =====
// Top level of the NMEA sentence type capture block: line parser, line buffer and word sequencer.
//
// Takes one received byte per request on the input channel. After reset all bytes are skipped
// up to the first newline; from then on each line is written into a line buffer of LINE_BYTES
// bytes. When the sixth byte of a line is stored, bytes 3..5 are checked against the two type
// code registers (index 0 first, then index 1). A matching line that ends in a newline is sent
// out as min(ceil(LINE_BYTES/8), 16) 64-bit words, byte 0 in bits 7..0, bytes not written in
// this line reading as zero, with last_word on the final word and overflowed set if the line
// did not fit. Other lines are dropped. Timing: while a line is being received, one byte is
// taken every cycle. The ending newline starts a burst in which the block takes no bytes; the
// words are read one at a time through the single registered read port of the line buffer,
// each word going through a read state and a load state and waiting in the load state while
// the output side stalls. The last word sits in the output register while the block
// already takes bytes of the next line. The buffer is never swept clear: the write pointer
// of the current line masks out stale bytes on readout. Type code writes are taken at any
// time and apply from the next header check.
module nmea_sentence_type_capture_core #(
  parameter int LINE_BYTES = nstc_pkg::LINE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [nstc_pkg::BYTE_W-1:0]    rx_byte,
  // word output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           frame_kind,
  output logic [nstc_pkg::WIDX_W-1:0]    word_index,
  output logic [nstc_pkg::WORD_W-1:0]    frame_word,
  output logic                           last_word,
  output logic                           overflowed,
  // type code register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nstc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nstc_pkg::CODE_W-1:0]    cfg_data
);
  import nstc_pkg::*;

  // Buffer geometry
  localparam int LINE_WORDS = (LINE_BYTES + 7) / 8;
  localparam int EMIT_WORDS = (LINE_WORDS > MAX_WORDS) ? MAX_WORDS : LINE_WORDS;
  localparam int MEM_AW     = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int WCNT_W     = (EMIT_WORDS > 1) ? $clog2(EMIT_WORDS) : 1;
  localparam int POS_W      = $clog2(LINE_BYTES + 1);
  localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(EMIT_WORDS - 1);

  // Type code registers
  logic [CODE_W-1:0] type_code_first;
  logic [CODE_W-1:0] type_code_second;

  // Parser state
  phase_t            phase, phase_next;
  logic [2:0]        hdr_cnt, hdr_cnt_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic              ovf, ovf_next;
  logic [BYTE_W-1:0] hdr3, hdr4;
  logic              cap3, cap4;

  // Sequencer state
  seq_t              seq;
  logic [WCNT_W-1:0] word_cnt;
  logic              emit_kind, emit_kind_next;
  logic              emit_start;

  // Line buffer, 64-bit words with byte lane writes
  logic [WORD_W-1:0] line_mem [LINE_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] rd_masked;

  logic              in_fire;
  logic              out_free;
  logic              put_req;
  logic [POS_W-1:0]  put_pos;
  logic              mem_we;
  logic [CODE_W-1:0] hdr_code;

  assign cfg_ready = 1'b1;
  assign in_ready  = (seq == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign hdr_code  = {hdr3, hdr4, rx_byte};

  // Type code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      type_code_first  <= CODE_FIRST_RST;
      type_code_second <= CODE_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TYPE_FIRST) begin
        type_code_first <= cfg_data;
      end else if (cfg_index == CFG_TYPE_SECOND) begin
        type_code_second <= cfg_data;
      end
    end
  end

  // Line parser
  always_comb begin
    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    pos_next       = pos;
    ovf_next       = ovf;
    emit_kind_next = emit_kind;
    emit_start     = 1'b0;
    put_req        = 1'b0;
    put_pos        = pos;
    mem_we         = 1'b0;
    cap3           = 1'b0;
    cap4           = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_WAIT: begin
          if (rx_byte == NEWLINE) phase_next = PH_START;
        end
        PH_START: begin
          // new line: the fill pointer restarts, stale bytes are masked on readout
          put_req      = 1'b1;
          put_pos      = '0;
          ovf_next     = 1'b0;
          hdr_cnt_next = '0;
          phase_next   = PH_HEADER;
        end
        PH_HEADER: begin
          // newlines are stored like any other header byte
          put_req = 1'b1;
          cap3    = (hdr_cnt == 3'd2);
          cap4    = (hdr_cnt == 3'd3);
          if (hdr_cnt == 3'd4) begin
            hdr_cnt_next = '0;
            if (hdr_code == type_code_first) begin
              phase_next = PH_KIND0;
            end else if (hdr_code == type_code_second) begin
              phase_next = PH_KIND1;
            end else begin
              phase_next = PH_OTHER;
            end
          end else begin
            hdr_cnt_next = hdr_cnt + 3'd1;
          end
        end
        PH_KIND0, PH_KIND1: begin
          if (rx_byte == NEWLINE) begin
            emit_start     = 1'b1;
            emit_kind_next = (phase == PH_KIND1);
            phase_next     = PH_START;
          end else begin
            put_req = 1'b1;
          end
        end
        PH_OTHER: begin
          if (rx_byte == NEWLINE) phase_next = PH_START;
          else                    put_req    = 1'b1;
        end
        default: phase_next = PH_WAIT;
      endcase
      if (put_req) begin
        if (put_pos < POS_W'(LINE_BYTES)) begin
          mem_we   = 1'b1;
          pos_next = put_pos + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      hdr_cnt   <= '0;
      pos       <= '0;
      ovf       <= 1'b0;
      emit_kind <= 1'b0;
    end else begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      pos       <= pos_next;
      ovf       <= ovf_next;
      emit_kind <= emit_kind_next;
    end
  end

  // Header letters 3 and 4; letter 5 is compared straight off the input
  always_ff @(posedge clk) begin
    if (cap3) hdr3 <= rx_byte;
    if (cap4) hdr4 <= rx_byte;
  end

  // Line buffer: one byte lane write, one registered word read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[MEM_AW'(put_pos >> 3)][put_pos[2:0]*BYTE_W +: BYTE_W] <= rx_byte;
    end
    rd_data <= line_mem[MEM_AW'(word_cnt)];
  end

  // Zero the bytes at or beyond the fill pointer
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      rd_masked[b*BYTE_W +: BYTE_W] =
        ((int'(word_cnt) * 8 + b) < int'(pos)) ? rd_data[b*BYTE_W +: BYTE_W] : '0;
    end
  end

  // Word sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= ST_IDLE;
      word_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (seq == ST_LOAD && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (seq)
        ST_IDLE: begin
          if (emit_start) begin
            word_cnt <= '0;
            seq      <= ST_READ;
          end
        end
        ST_READ: seq <= ST_LOAD;
        ST_LOAD: begin
          if (out_free) begin
            if (word_cnt == LAST_WORD) begin
              seq <= ST_IDLE;
            end else begin
              word_cnt <= word_cnt + 1'b1;
              seq      <= ST_READ;
            end
          end
        end
        default: seq <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (seq == ST_LOAD && out_free) begin
      frame_kind <= emit_kind;
      word_index <= WIDX_W'(word_cnt);
      frame_word <= rd_masked;
      last_word  <= (word_cnt == LAST_WORD);
      overflowed <= ovf;
    end
  end

endmodule

// ===== test/tb_nmea_sentence_type_capture_core.sv =====
// Testbench for nmea_sentence_type_capture_core: directed byte table, then random sentences.
module tb_nmea_sentence_type_capture_core;
  import nstc_pkg::*;

  localparam int LB          = LINE_BYTES_DEF;
  localparam int STALL_LIMIT = 3000;  // cycles with no request moving at all
  localparam int DRAIN_WAIT  = 48;    // wait for the readout burst to end

  // cfg_index values the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  // One emitted buffer word as the block reports it.
  typedef struct {
    logic                kind;
    logic [WIDX_W-1:0]   index;
    logic [WORD_W-1:0]   data;
    logic                last;
    logic                ovf;
  } line_word_t;

  // Directed row: one byte; rows that end a matched line may carry a typed kind and word 0.
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              typed;
    logic              kind;
    logic [WORD_W-1:0] word0;
  } byte_row_t;

  localparam int N_ROWS = 26;
  localparam byte_row_t BYTE_SCRIPT [N_ROWS] = '{
    '{8'h78, 1'b0, 1'b0, 64'h0},               // skipped: still waiting for a newline
    '{8'hFF, 1'b0, 1'b0, 64'h0},               // skipped, all ones
    '{8'h0A, 1'b0, 1'b0, 64'h0},               // first newline, next byte starts a line
    '{8'h24, 1'b0, 1'b0, 64'h0},               // '$'
    '{8'h47, 1'b0, 1'b0, 64'h0},               // 'G'
    '{8'h50, 1'b0, 1'b0, 64'h0},               // 'P'
    '{8'h47, 1'b0, 1'b0, 64'h0},               // 'G'
    '{8'h47, 1'b0, 1'b0, 64'h0},               // 'G'
    '{8'h41, 1'b0, 1'b0, 64'h0},               // 'A' -> header check, kind 0
    '{8'h00, 1'b0, 1'b0, 64'h0},               // all zeros in the body
    '{8'hFF, 1'b0, 1'b0, 64'h0},               // all ones in the body
    '{8'h0A, 1'b1, 1'b0, 64'hFF00_4147_4750_4724}, // end of GGA line
    '{8'h0A, 1'b0, 1'b0, 64'h0},               // newline as first byte of a line is stored
    '{8'h0A, 1'b0, 1'b0, 64'h0},               // newline inside the header is stored
    '{8'h0A, 1'b0, 1'b0, 64'h0},
    '{8'h52, 1'b0, 1'b0, 64'h0},               // 'R'
    '{8'h4D, 1'b0, 1'b0, 64'h0},               // 'M'
    '{8'h43, 1'b0, 1'b0, 64'h0},               // 'C' -> kind 1
    '{8'h0A, 1'b1, 1'b1, 64'h0000_434D_520A_0A0A}, // stale bytes 6,7 of last line read zero
    '{8'h24, 1'b0, 1'b0, 64'h0},               // '$' GNGSV: not a configured type
    '{8'h47, 1'b0, 1'b0, 64'h0},
    '{8'h4E, 1'b0, 1'b0, 64'h0},
    '{8'h47, 1'b0, 1'b0, 64'h0},
    '{8'h53, 1'b0, 1'b0, 64'h0},
    '{8'h56, 1'b0, 1'b0, 64'h0},
    '{8'h0A, 1'b0, 1'b0, 64'h0}                // dropped line, nothing out
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 frame_kind;
  logic [WIDX_W-1:0]    word_index;
  logic [WORD_W-1:0]    frame_word;
  logic                 last_word;
  logic                 overflowed;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0]    cfg_data = '0;

  nmea_sentence_type_capture_core #(.LINE_BYTES(LB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_kind(frame_kind), .word_index(word_index), .frame_word(frame_word),
    .last_word(last_word), .overflowed(overflowed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line tracker: our own copy of the parser state, buffer and type codes.
  // ---------------------------------------------------------------------------
  phase_t            trk_phase = PH_WAIT;
  int                hdr_seen;
  int                fill;          // bytes stored in the current line
  logic [BYTE_W-1:0] line_buf [LB];
  bit                line_cut;      // line ran past the buffer
  logic [CODE_W-1:0] code_first  = CODE_FIRST_RST;
  logic [CODE_W-1:0] code_second = CODE_SECOND_RST;

  line_word_t        words_due [$]; // expected words, oldest first

  int  fail_count = 0;
  int  shown = 0;
  bit  steady = 1'b0;               // no gaps on either side while set
  logic [BYTE_W-1:0] byte_plan [$];

  function automatic void store_byte(input logic [BYTE_W-1:0] b);
    if (fill < LB) begin
      line_buf[fill] = b;
      fill++;
    end else begin
      line_cut = 1'b1;
    end
  endfunction

  function automatic bit header_hits(input logic [CODE_W-1:0] code);
    return line_buf[3] == code[23:16] && line_buf[4] == code[15:8] && line_buf[5] == code[7:0];
  endfunction

  // Whole buffer goes out; bytes at or past the fill point are zero since the
  // buffer is cleared at each line start.
  function automatic void queue_line(input logic kind);
    int         nwords;
    int         a;
    line_word_t w;
    nwords = (LB + 7) / 8;
    if (nwords > MAX_WORDS) nwords = MAX_WORDS;
    for (int i = 0; i < nwords; i++) begin
      w.kind  = kind;
      w.index = WIDX_W'(i);
      w.data  = '0;
      for (int k = 0; k < 8; k++) begin
        a = i * 8 + k;
        if (a < LB) w.data[8*k +: 8] = line_buf[a];
      end
      w.last = (i == nwords - 1);
      w.ovf  = line_cut;
      words_due.push_back(w);
    end
  endfunction

  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    case (trk_phase)
      PH_WAIT: if (b == NEWLINE) trk_phase = PH_START;
      PH_START: begin
        for (int i = 0; i < LB; i++) line_buf[i] = '0;
        fill      = 0;
        line_cut  = 1'b0;
        hdr_seen  = 0;
        store_byte(b);
        trk_phase = PH_HEADER;
      end
      PH_HEADER: begin
        // newlines here are just header bytes
        store_byte(b);
        hdr_seen = (hdr_seen + 1) & 7;
        if (hdr_seen >= 5) begin
          hdr_seen = 0;
          if (header_hits(code_first))       trk_phase = PH_KIND0;
          else if (header_hits(code_second)) trk_phase = PH_KIND1;
          else                               trk_phase = PH_OTHER;
        end
      end
      PH_KIND0, PH_KIND1: begin
        if (b == NEWLINE) begin
          queue_line(trk_phase == PH_KIND1);
          trk_phase = PH_START;
        end else begin
          store_byte(b);
        end
      end
      PH_OTHER: begin
        if (b == NEWLINE) trk_phase = PH_START;
        else              store_byte(b);
      end
      default: trk_phase = PH_WAIT;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady)  return 0;
    if (r < 60)  return 0;
    if (r < 92)  return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] upper_letter();
    return BYTE_W'($urandom_range(65, 90));
  endfunction

  function automatic int pick_body_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 24);
    return $urandom_range(25, 60);
  endfunction

  // Plans one sentence into byte_plan. sel: 0 first code, 1 second, else random choice.
  // Some sentences get stray bytes ahead of them or a newline inside the header.
  function automatic void plan_sentence(input int sel, input int body_len);
    int                r;
    int                cut;
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] hdr [6];
    logic [BYTE_W-1:0] b;
    r = $urandom_range(0, 99);
    if (sel == 0)       code = code_first;
    else if (sel == 1)  code = code_second;
    else if (r < 35)    code = code_first;
    else if (r < 65)    code = code_second;
    else if (r < 85)    code = {upper_letter(), upper_letter(), upper_letter()};
    else                code = CODE_W'($urandom);
    if (sel < 0 && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) byte_plan.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    hdr[0] = ($urandom_range(0, 9) != 0) ? 8'h24 : BYTE_W'($urandom_range(0, 255));
    hdr[1] = upper_letter();
    hdr[2] = upper_letter();
    hdr[3] = code[23:16];
    hdr[4] = code[15:8];
    hdr[5] = code[7:0];
    cut = (sel < 0 && $urandom_range(0, 19) == 0) ? $urandom_range(1, 5) : 6;
    for (int i = 0; i < cut; i++) byte_plan.push_back(hdr[i]);
    if (cut < 6) begin
      byte_plan.push_back(NEWLINE);
      return;
    end
    for (int i = 0; i < body_len; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (b == NEWLINE) b = 8'h2C;
      byte_plan.push_back(b);
    end
    byte_plan.push_back(NEWLINE);
  endfunction

  // ---------------------------------------------------------------------------
  // Request drivers. Each is entered right after a rising edge; send_byte returns right
  // after the edge that took its request, write_code once it has dropped cfg_valid again;
  // handshakes are looked at on the falling edge, where everything has settled.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input logic kind, input logic [WORD_W-1:0] word0);
    int gap;
    int n0;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(negedge clk); while (!in_ready);
    // taken at the coming edge; typed rows replace word 0 with the hand value
    n0 = words_due.size();
    track_byte(b);
    if (typed && words_due.size() > n0) begin
      words_due[n0].kind = kind;
      words_due[n0].data = word0;
    end
    @(posedge clk);
  endtask

  task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    if (idx == CFG_TYPE_FIRST)       code_first  = value;
    else if (idx == CFG_TYPE_SECOND) code_second = value;
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Block is idle once every word is out and the readout burst has surely ended.
  task automatic drain();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CODE_W-1:0] first, input logic [CODE_W-1:0] second,
                           input int budget, input int long_body, input bit spare_writes);
    drain();
    write_code(CFG_TYPE_FIRST, first);
    write_code(CFG_TYPE_SECOND, second);
    if (spare_writes) begin
      write_code(CFG_SPARE2, CODE_W'($urandom));
      write_code(CFG_SPARE3, CODE_W'($urandom));
    end
    byte_plan.delete();
    if (long_body >= 0) plan_sentence(0, long_body);
    while (byte_plan.size() < budget) plan_sentence(-1, pick_body_len());
    foreach (byte_plan[i]) send_byte(byte_plan[i], 1'b0, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, long ones now and then; always ready while steady is set.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if ($urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  // Word checker: compare each taken word with the oldest expected one.
  always @(negedge clk) begin : check_words
    line_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        fail_count++;
        if (shown < 10)
          $display("unexpected word: kind=%0d idx=%0d word=%h last=%0d ovf=%0d",
                   frame_kind, word_index, frame_word, last_word, overflowed);
        shown++;
      end else begin
        want = words_due.pop_front();
        if (want.kind !== frame_kind || want.index !== word_index || want.data !== frame_word ||
            want.last !== last_word || want.ovf !== overflowed) begin
          fail_count++;
          if (shown < 10) begin
            $display("word mismatch: exp kind=%0d idx=%0d word=%h last=%0d ovf=%0d",
                     want.kind, want.index, want.data, want.last, want.ovf);
            $display("               got kind=%0d idx=%0d word=%h last=%0d ovf=%0d",
                     frame_kind, word_index, frame_word, last_word, overflowed);
          end
          shown++;
        end
      end
    end
  end

  // Watchdog: the run is declared hung when the quiet counter, reset by any handshake, reaches STALL_LIMIT.
  int quiet = 0;
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_nmea_sentence_type_capture_core: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CODE_W-1:0] same_code;
    for (int i = 0; i < LB; i++) line_buf[i] = '0;
    hdr_seen = 0;
    fill     = 0;
    line_cut = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table, reset type codes (GGA / RMC).
    for (int i = 0; i < N_ROWS; i++)
      send_byte(BYTE_SCRIPT[i].b, BYTE_SCRIPT[i].typed, BYTE_SCRIPT[i].kind,
                BYTE_SCRIPT[i].word0);

    // Extreme codes; one line fills the buffer exactly (6 header + 122 body).
    run_phase('0, '1, 130, 122, 1'b0);
    // Both codes equal: matches must report kind 0.
    same_code = {upper_letter(), upper_letter(), upper_letter()};
    run_phase(same_code, same_code, 30, -1, 1'b0);
    // Random codes, writes to unused indexes, one line past the buffer end.
    run_phase(CODE_W'($urandom), CODE_W'($urandom), 140, 130, 1'b1);
    // Back to reset codes with no gaps on either side.
    steady = 1'b1;
    run_phase(CODE_FIRST_RST, CODE_SECOND_RST, 30, -1, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("tb_nmea_sentence_type_capture_core: done, clean");
    end else begin
      $display("tb_nmea_sentence_type_capture_core: done, errors");
    end
    $finish;
  end

endmodule
